[src/modular_arithmetic_unit_defines.svh]
// Assertion macros shared by the RTL.
`ifndef MODULAR_ARITHMETIC_UNIT_DEFINES_SVH
`define MODULAR_ARITHMETIC_UNIT_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define MAU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define MAU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/mau_pkg.sv]
package mau_pkg;

    localparam int RW = 31;
    localparam int EW = 63;
    localparam int RAW_W = 64;
    localparam int PW = 2 * RW;
    localparam int CNT_W = 7;             // remainder step counter, up to RAW_W
    localparam int BIT_W = $clog2(EW);    // exponent bit index
    localparam logic [RW-1:0] MODULUS_RESET = RW'(1000000007);

    typedef enum logic [2:0] {
        CMD_REDUCE   = 3'd0,
        CMD_ADD      = 3'd1,
        CMD_SUB      = 3'd2,
        CMD_MUL      = 3'd3,
        CMD_DIV      = 3'd4,
        CMD_POW      = 3'd5,
        CMD_CMP      = 3'd6,
        CMD_RSVD     = 3'd7
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RED_A,
        ST_RED_B,
        ST_MOD,
        ST_DISPATCH,
        ST_RAW_FIX,
        ST_EXP_SQ,
        ST_SQ_DONE,
        ST_EXP_MUL,
        ST_MUL_DONE,
        ST_FIN_MUL,
        ST_FIN_DONE,
        ST_FINAL
    } state_t;

    typedef struct packed {
        logic [2:0]       command;
        logic [RW-1:0]    operand_a;
        logic [RW-1:0]    operand_b;
        logic [RAW_W-1:0] raw_value;
        logic [EW-1:0]    exponent;
    } in_item_t;

    typedef struct packed {
        logic [RW-1:0] result;
        logic          is_less;
        logic          is_equal;
    } out_item_t;

endpackage

[src/modular_arithmetic_unit.sv]
// Both operands are first reduced on one shared restoring remainder unit (one bit per
// cycle); every modular multiply also runs on the same unit.
// Flow: one item at a time, in_stall high while busy; the next transfer is taken in
// the cycle after the result is parked. Reset (rst_n, async, low): idle, modulus 1000000007.
module modular_arithmetic_unit
    import mau_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [RW-1:0]  cfg_wdata,
    input  logic           in_valid,
    output logic           in_stall,
    input  in_item_t       in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output out_item_t      out_data
);
`include "modular_arithmetic_unit_defines.svh"

    logic [RW-1:0]    modulus_reg;
    state_t           state_reg, state_next;
    state_t           ret_reg;      // where a reduction returns
    in_item_t         item_reg;
    logic [RW-1:0]    a_reg, b_reg, acc_reg, base_reg;
    logic [RW-1:0]    rem_reg;      // running remainder, always below m
    logic [RAW_W-1:0] dvd_reg;      // dividend bits, MSB first
    logic [CNT_W-1:0] cnt_reg;      // dividend bits still to shift in
    logic [BIT_W-1:0] bit_reg;      // exponent bit index
    logic [EW-1:0]    exp_reg;
    logic             neg_reg;
    out_item_t        out_reg;
    logic             out_valid_reg;

    logic [RW-1:0]    m;
    cmd_t             cmd;
    logic [RW:0]      shifted;
    logic [RW+1:0]    diff;
    logic [RW-1:0]    rem_step;
    logic [RW-1:0]    mul_y;
    logic [PW-1:0]    prod;
    logic [RW:0]      sum;
    logic [RW-1:0]    mod_sum;
    logic [RW-1:0]    mod_diff;
    logic             exp_last;
    logic             out_load;
    out_item_t        out_value;

    // modulus 0 behaves as modulus 1
    assign m = (modulus_reg == '0) ? RW'(1) : modulus_reg;
    assign cmd = cmd_t'(item_reg.command);
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    // one restoring remainder step: shift in the next dividend bit, subtract if it fits
    assign shifted = {rem_reg, dvd_reg[RAW_W-1]};
    assign diff = {1'b0, shifted} - {2'b00, m};
    assign rem_step = diff[RW+1] ? shifted[RW-1:0] : diff[RW-1:0];

    // shared multiplier: square, times base, or final times a
    assign mul_y = (state_reg == ST_EXP_SQ)  ? acc_reg
                 : (state_reg == ST_EXP_MUL) ? base_reg
                 : a_reg;
    assign prod = PW'(acc_reg) * PW'(mul_y);

    // add and subtract on already reduced operands
    assign sum = {1'b0, a_reg} + {1'b0, b_reg};
    assign mod_sum = (sum >= {1'b0, m}) ? RW'(sum - {1'b0, m}) : sum[RW-1:0];
    assign mod_diff = (a_reg >= b_reg) ? a_reg - b_reg
                    : RW'({1'b0, a_reg} + {1'b0, m} - {1'b0, b_reg});

    assign exp_last = (bit_reg == '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (in_valid) state_next = ST_RED_A;
            ST_RED_A, ST_RED_B, ST_EXP_SQ, ST_EXP_MUL, ST_FIN_MUL:
                state_next = ST_MOD;
            ST_MOD:      if (cnt_reg == '0) state_next = ret_reg;
            ST_DISPATCH:
            begin
                case (cmd)
                    CMD_REDUCE: state_next = ST_MOD;
                    CMD_MUL:    state_next = ST_FIN_MUL;
                    CMD_DIV:    state_next = (rem_reg == '0) ? ST_FINAL : ST_EXP_SQ;
                    CMD_POW:    state_next = ST_EXP_SQ;
                    default:    state_next = ST_FINAL;
                endcase
            end
            ST_RAW_FIX:  state_next = ST_FINAL;
            ST_SQ_DONE:
            begin
                if (exp_reg[bit_reg])
                    state_next = ST_EXP_MUL;
                else if (exp_last)
                    state_next = (cmd == CMD_DIV) ? ST_FIN_MUL : ST_FINAL;
                else
                    state_next = ST_EXP_SQ;
            end
            ST_MUL_DONE:
            begin
                if (exp_last)
                    state_next = (cmd == CMD_DIV) ? ST_FIN_MUL : ST_FINAL;
                else
                    state_next = ST_EXP_SQ;
            end
            ST_FIN_DONE: state_next = ST_FINAL;
            ST_FINAL:    if (!out_valid_reg || !out_stall) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb
    begin
        in_stall = 1'b1;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE:  in_stall = 1'b0;
            ST_FINAL: out_load = !out_valid_reg || !out_stall;
            default:  ;
        endcase
    end

    // result fields by command
    always_comb
    begin
        out_value = '0;
        case (cmd)
            CMD_REDUCE, CMD_MUL, CMD_DIV, CMD_POW: out_value.result = acc_reg;
            CMD_ADD: out_value.result = mod_sum;
            CMD_SUB: out_value.result = mod_diff;
            CMD_CMP:
            begin
                // compare looks at the fields as given, not reduced
                out_value.is_less  = item_reg.operand_a < item_reg.operand_b;
                out_value.is_equal = item_reg.operand_a == item_reg.operand_b;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            modulus_reg   <= MODULUS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we) modulus_reg <= cfg_wdata;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (in_valid) item_reg <= in_data;
            ST_RED_A:
            begin
                rem_reg <= '0;
                dvd_reg <= {item_reg.operand_a, {(RAW_W-RW){1'b0}}};
                cnt_reg <= CNT_W'(RW);
                ret_reg <= ST_RED_B;
            end
            ST_RED_B:
            begin
                a_reg   <= rem_reg;
                rem_reg <= '0;
                dvd_reg <= {item_reg.operand_b, {(RAW_W-RW){1'b0}}};
                cnt_reg <= CNT_W'(RW);
                ret_reg <= ST_DISPATCH;
            end
            ST_MOD:
                if (cnt_reg != '0)
                begin
                    rem_reg <= rem_step;
                    dvd_reg <= {dvd_reg[RAW_W-2:0], 1'b0};
                    cnt_reg <= cnt_reg - CNT_W'(1);
                end
            ST_DISPATCH:
            begin
                // rem_reg holds b mod m here
                b_reg    <= rem_reg;
                // power and nonzero divide start from 1 mod m; multiply keeps b
                acc_reg  <= ((cmd == CMD_POW) || (cmd == CMD_DIV && rem_reg != '0))
                            ? RW'(m != RW'(1)) : rem_reg;
                base_reg <= (cmd == CMD_DIV) ? rem_reg : a_reg;
                exp_reg  <= (cmd == CMD_DIV) ? EW'(m - RW'(2)) : item_reg.exponent;
                bit_reg  <= BIT_W'(EW - 1);
                // reduce: magnitude of the raw value through the remainder unit
                neg_reg  <= item_reg.raw_value[RAW_W-1];
                rem_reg  <= '0;
                dvd_reg  <= item_reg.raw_value[RAW_W-1] ? RAW_W'(0) - item_reg.raw_value
                                                        : item_reg.raw_value;
                cnt_reg  <= CNT_W'(RAW_W);
                ret_reg  <= ST_RAW_FIX;
            end
            ST_RAW_FIX:
                acc_reg <= (neg_reg && rem_reg != '0) ? m - rem_reg : rem_reg;
            ST_EXP_SQ, ST_EXP_MUL, ST_FIN_MUL:
            begin
                rem_reg <= '0;
                dvd_reg <= {prod, {(RAW_W-PW){1'b0}}};
                cnt_reg <= CNT_W'(PW);
                ret_reg <= (state_reg == ST_EXP_SQ)  ? ST_SQ_DONE
                         : (state_reg == ST_EXP_MUL) ? ST_MUL_DONE
                         : ST_FIN_DONE;
            end
            ST_SQ_DONE:
            begin
                acc_reg <= rem_reg;
                if (!exp_reg[bit_reg] && !exp_last) bit_reg <= bit_reg - BIT_W'(1);
            end
            ST_MUL_DONE:
            begin
                acc_reg <= rem_reg;
                if (!exp_last) bit_reg <= bit_reg - BIT_W'(1);
            end
            ST_FIN_DONE:
                acc_reg <= rem_reg;
            ST_FINAL:
                if (out_load) out_reg <= out_value;
            default: ;
        endcase
    end

    `MAU_ASSERT_IMP(a_busy_stall, state_reg != ST_IDLE, in_stall, "busy but not stalling")
    `MAU_ASSERT_NEXT(a_hold_out, out_valid_reg && out_stall, out_valid_reg && $stable(out_reg),
        "stalled result changed")
    `MAU_ASSERT_IMP(a_res_range, out_valid_reg && !$past(out_valid_reg), out_reg.result < m,
        "result not reduced")

endmodule
